/* hdl/mbrtu_pkg.sv */
// Shared types, codes and CRC helper for the Modbus RTU response deframer.
package mbrtu_pkg;

    localparam int MAX_FRAME = 256;
    localparam int LEN_W     = 10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [7:0] EXC_MASK  = 8'hF0;
    localparam logic [7:0] EXC_CODE  = 8'h80;
    localparam logic [7:0] FC_COIL   = 8'h05;
    localparam logic [7:0] FC_SINGLE = 8'h06;

    localparam logic [LEN_W-1:0] LEN_EXC    = 10'd5;
    localparam logic [LEN_W-1:0] LEN_FIXED  = 10'd8;
    localparam logic [LEN_W-1:0] LEN_TASK   = 10'd6;
    localparam logic [LEN_W-1:0] LEN_COUNT  = 10'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_CRC     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN = 3'd2;
    localparam logic [2:0] ST_GAP     = 3'd3;
    localparam logic [2:0] ST_LONG    = 3'd4;

    localparam logic [2:0] REG_SLAVE_ADDR  = 3'd0;
    localparam logic [2:0] REG_READ_FUNC   = 3'd1;
    localparam logic [2:0] REG_WRITE_FUNC  = 3'd2;
    localparam logic [2:0] REG_TASK_PEND   = 3'd3;
    localparam logic [2:0] REG_TASK_PARLEN = 3'd4;

    localparam logic OP_BYTE = 1'b0;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last;
        logic [2:0] status;
    } result_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] index;
        logic [7:0] data;
    } cfg_wr_t;

    function automatic logic [15:0] crc_add(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* hdl/modbus_rtu_response_deframer_top.sv */
// Top level of the Modbus RTU response deframer.
// Takes one received byte or gap event per clock whenever full is low and
// gives at most one result word per input: every byte of a response frame
// from the address byte on, the final one flagged last with its CRC-16
// status, or a single abort word (byte zero, last set) for an unknown
// function code, an oversized frame or a gap inside a frame. The parser
// handles a new word every cycle; its CRC update is one byte per clock.
// Results wait in a QUEUE_DEPTH-word queue, so input stalls only when that
// queue is full. Configuration writes are always ready and apply to input
// words accepted from the following clock on.
module modbus_rtu_response_deframer_top
    import mbrtu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  item_t      item,
    output logic       empty,
    input  logic       pop,
    output result_t    result,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    cfg_wr_t cfg;
    logic    accept;
    logic    res_valid;
    result_t res;

    assign cfg_ready = 1'b1;
    assign cfg       = '{valid: cfg_valid && cfg_ready, index: cfg_index, data: cfg_data};
    assign accept    = push && !full;

    mbrtu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    mbrtu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (res_valid),
        .wr_data (res),
        .rd      (pop),
        .rd_data (result),
        .full    (full),
        .empty   (empty)
    );

    a_not_full_and_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue reports full and empty together");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.status <= ST_LONG))
        else $error("result status out of range");

    a_mid_frame_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.last) |-> (result.status == ST_OK))
        else $error("non-final word carries an error status");

    a_abort_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (result.status == ST_UNKNOWN || result.status == ST_GAP
                    || result.status == ST_LONG)) |-> (result.frame_byte == 8'h00))
        else $error("abort word carries a nonzero byte");

    a_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (full && !pop) |=> full)
        else $error("queue drained without a pop");

endmodule

/* hdl/mbrtu_front.sv */
// Front end: config registers, frame parser and CRC; produces at most one result word per byte.
module mbrtu_front
    import mbrtu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  logic    accept,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    localparam logic [1:0] PH_HUNT  = 2'd0;
    localparam logic [1:0] PH_FUNC  = 2'd1;
    localparam logic [1:0] PH_COUNT = 2'd2;
    localparam logic [1:0] PH_BODY  = 2'd3;

    logic [7:0]  slave_addr_reg, read_func_reg, write_func_reg, task_parlen_reg;
    logic        task_pend_reg;

    logic [1:0]  phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [8:0]  exp_len_reg, exp_len_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  crc_lo_reg, crc_lo_next;

    logic [7:0]       b;
    logic [15:0]      crc_upd;
    logic [LEN_W-1:0] len;
    logic             known;
    logic             is_read;
    logic [LEN_W-1:0] pos_ext;

    assign b       = item.rx_byte;
    assign crc_upd = crc_add(crc_reg, b);
    assign pos_ext = {1'b0, pos_reg} + 10'd2;

    // length rules for the function code byte, first match wins
    always_comb
    begin
        known   = 1'b1;
        is_read = 1'b0;
        len     = '0;
        priority if ((b & EXC_MASK) == EXC_CODE)
            len = LEN_EXC;
        else if (b == FC_COIL)
            len = LEN_FIXED;
        else if (b == FC_SINGLE && task_pend_reg)
            len = {2'b00, task_parlen_reg} + LEN_TASK;
        else if (b == read_func_reg)
            is_read = 1'b1;
        else if (b == write_func_reg)
            len = LEN_FIXED;
        else
            known = 1'b0;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        exp_len_next = exp_len_reg;
        crc_next     = crc_reg;
        crc_lo_next  = crc_lo_reg;
        res_valid    = 1'b0;
        res          = '0;
        if (accept) begin
            if (item.operation != OP_BYTE) begin
                if (phase_reg != PH_HUNT) begin
                    phase_next = PH_HUNT;
                    pos_next   = '0;
                    res_valid  = 1'b1;
                    res        = '{frame_byte: 8'h00, last: 1'b1, status: ST_GAP};
                end
            end else begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (b == slave_addr_reg) begin
                            crc_next   = crc_add(CRC_INIT, b);
                            pos_next   = 9'd1;
                            phase_next = PH_FUNC;
                            res_valid  = 1'b1;
                            res        = '{frame_byte: b, last: 1'b0, status: ST_OK};
                        end
                    end
                    PH_FUNC:
                    begin
                        res_valid = 1'b1;
                        if (!known) begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                            res        = '{frame_byte: 8'h00, last: 1'b1, status: ST_UNKNOWN};
                        end else if (len > LEN_W'(MAX_FRAME)) begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                            res        = '{frame_byte: 8'h00, last: 1'b1, status: ST_LONG};
                        end else begin
                            exp_len_next = len[8:0];
                            crc_next     = crc_upd;
                            pos_next     = 9'd2;
                            phase_next   = is_read ? PH_COUNT : PH_BODY;
                            res          = '{frame_byte: b, last: 1'b0, status: ST_OK};
                        end
                    end
                    PH_COUNT:
                    begin
                        res_valid = 1'b1;
                        if (({2'b00, b} + LEN_COUNT) > LEN_W'(MAX_FRAME)) begin
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                            res        = '{frame_byte: 8'h00, last: 1'b1, status: ST_LONG};
                        end else begin
                            exp_len_next = 9'({2'b00, b} + LEN_COUNT);
                            crc_next     = crc_upd;
                            pos_next     = 9'd3;
                            phase_next   = PH_BODY;
                            res          = '{frame_byte: b, last: 1'b0, status: ST_OK};
                        end
                    end
                    PH_BODY:
                    begin
                        res_valid = 1'b1;
                        pos_next  = pos_reg + 9'd1;
                        if (pos_ext < {1'b0, exp_len_reg}) begin
                            crc_next = crc_upd;
                            res      = '{frame_byte: b, last: 1'b0, status: ST_OK};
                        end else if (pos_ext == {1'b0, exp_len_reg}) begin
                            crc_lo_next = b;
                            res         = '{frame_byte: b, last: 1'b0, status: ST_OK};
                        end else begin
                            // trailer high byte: compare little-endian CRC
                            phase_next = PH_HUNT;
                            pos_next   = '0;
                            res        = '{frame_byte: b, last: 1'b1,
                                           status: (crc_reg == {b, crc_lo_reg}) ? ST_OK : ST_CRC};
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            slave_addr_reg  <= 8'd1;
            read_func_reg   <= 8'd3;
            write_func_reg  <= 8'd16;
            task_pend_reg   <= 1'b0;
            task_parlen_reg <= 8'd0;
            phase_reg       <= PH_HUNT;
            pos_reg         <= '0;
            exp_len_reg     <= '0;
            crc_reg         <= CRC_INIT;
            crc_lo_reg      <= '0;
        end else begin
            phase_reg   <= phase_next;
            pos_reg     <= pos_next;
            exp_len_reg <= exp_len_next;
            crc_reg     <= crc_next;
            crc_lo_reg  <= crc_lo_next;
            if (cfg.valid) begin
                unique case (cfg.index)
                    REG_SLAVE_ADDR:  slave_addr_reg  <= cfg.data;
                    REG_READ_FUNC:   read_func_reg   <= cfg.data;
                    REG_WRITE_FUNC:  write_func_reg  <= cfg.data;
                    REG_TASK_PEND:   task_pend_reg   <= cfg.data[0];
                    REG_TASK_PARLEN: task_parlen_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

/* hdl/mbrtu_queue.sv */
// Back end: result queue that decouples the parser from the consumer.
module mbrtu_queue
    import mbrtu_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr,
    input  result_t wr_data,
    input  logic    rd,
    output result_t rd_data,
    output logic    full,
    output logic    empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t        mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the Modbus RTU response deframer.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mbrtu_pkg::*;

    localparam logic OP_GAP       = 1'b1;
    localparam int   UNKNOWN_CODE = -1;
    localparam int   NEEDS_COUNT  = 0;
    localparam int   STALL_LIMIT  = 2000;
    localparam int   SETTLE_CYCLES = 8;

    typedef enum logic [1:0] {HUNT, WAIT_FUNC, WAIT_COUNT, IN_BODY} parse_phase_e;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       push      = 1'b0;
    logic       full;
    item_t      item      = '0;
    logic       empty;
    logic       pop       = 1'b0;
    result_t    result;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = REG_SLAVE_ADDR;
    logic [7:0] cfg_data  = '0;

    modbus_rtu_response_deframer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // register copy, updated when a write handshake completes
    logic [7:0] mir_slave     = 8'd1;
    logic [7:0] mir_read      = 8'd3;
    logic [7:0] mir_write     = 8'd16;
    logic       mir_task_pend = 1'b0;
    logic [7:0] mir_task_len  = 8'd0;

    // parser state of the predictor
    parse_phase_e parse_phase = HUNT;
    int           byte_pos    = 0;
    int           frame_len   = 0;
    logic [15:0]  crc_acc     = CRC_INIT;
    logic [7:0]   crc_low     = '0;

    item_t   pending[$];
    result_t frame_words_due[$];

    int  queued_items   = 0;
    int  items_accepted = 0;
    int  words_seen     = 0;
    int  mismatches     = 0;
    int  settings_used  = 1;
    int  frames_ok      = 0;
    int  frames_bad_crc = 0;
    int  aborts_unknown = 0;
    int  aborts_gap     = 0;
    int  aborts_long    = 0;
    int  feed_hold      = 0;
    int  drain_hold     = 0;
    int  quiet_cycles   = 0;
    bit  steady_feed    = 1'b0;
    bit  steady_drain   = 1'b0;

    // bit-serial form of the reflected CRC-16 update
    function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
        logic fb;
        for (int i = 0; i < 8; i++)
        begin
            fb  = crc[0] ^ b[i];
            crc = crc >> 1;
            if (fb)
                crc = crc ^ CRC_POLY;
        end
        return crc;
    endfunction

    // first matching rule wins; NEEDS_COUNT means the byte count decides
    function automatic int frame_length(logic [7:0] fc);
        if ((fc & EXC_MASK) == EXC_CODE)
            return int'(LEN_EXC);
        if (fc == FC_COIL)
            return int'(LEN_FIXED);
        if (fc == FC_SINGLE && mir_task_pend)
            return int'(mir_task_len) + int'(LEN_TASK);
        if (fc == mir_read)
            return NEEDS_COUNT;
        if (fc == mir_write)
            return int'(LEN_FIXED);
        return UNKNOWN_CODE;
    endfunction

    function automatic void due_word(logic [7:0] b, logic last, logic [2:0] st);
        result_t w;
        w.frame_byte = b;
        w.last       = last;
        w.status     = st;
        frame_words_due.push_back(w);
    endfunction

    function automatic void abort_frame(logic [2:0] st);
        parse_phase = HUNT;
        byte_pos    = 0;
        due_word(8'h00, 1'b1, st);
    endfunction

    function automatic void deframe_word(item_t it);
        int p;
        int len;
        logic [7:0] b;
        b = it.rx_byte;
        if (it.operation == OP_GAP)
        begin
            if (parse_phase != HUNT)
                abort_frame(ST_GAP);
            return;
        end
        case (parse_phase)
            HUNT:
            begin
                if (b == mir_slave)
                begin
                    crc_acc     = crc16_step(CRC_INIT, b);
                    byte_pos    = 1;
                    parse_phase = WAIT_FUNC;
                    due_word(b, 1'b0, ST_OK);
                end
            end
            WAIT_FUNC:
            begin
                len = frame_length(b);
                if (len == UNKNOWN_CODE)
                    abort_frame(ST_UNKNOWN);
                else if (len > MAX_FRAME)
                    abort_frame(ST_LONG);
                else
                begin
                    crc_acc     = crc16_step(crc_acc, b);
                    byte_pos    = 2;
                    frame_len   = len;
                    parse_phase = (len == NEEDS_COUNT) ? WAIT_COUNT : IN_BODY;
                    due_word(b, 1'b0, ST_OK);
                end
            end
            WAIT_COUNT:
            begin
                frame_len = int'(b) + int'(LEN_COUNT);
                if (frame_len > MAX_FRAME)
                    abort_frame(ST_LONG);
                else
                begin
                    crc_acc     = crc16_step(crc_acc, b);
                    byte_pos    = 3;
                    parse_phase = IN_BODY;
                    due_word(b, 1'b0, ST_OK);
                end
            end
            default:
            begin
                p        = byte_pos;
                byte_pos = (p + 1) & 'h1FF;
                if (p + 2 < frame_len)
                begin
                    crc_acc = crc16_step(crc_acc, b);
                    due_word(b, 1'b0, ST_OK);
                end
                else if (p + 2 == frame_len)
                begin
                    crc_low = b;
                    due_word(b, 1'b0, ST_OK);
                end
                else
                begin
                    parse_phase = HUNT;
                    byte_pos    = 0;
                    due_word(b, 1'b1, (crc_acc == {b, crc_low}) ? ST_OK : ST_CRC);
                end
            end
        endcase
    endfunction

    function automatic void check_word(result_t got);
        result_t want;
        if (frame_words_due.size() == 0)
        begin
            $error("result word %0h arrived with nothing expected", got);
            mismatches++;
            return;
        end
        want = frame_words_due.pop_front();
        words_seen++;
        if (got.frame_byte !== want.frame_byte)
        begin
            $error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
            mismatches++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0h, got %0h", want.last, got.last);
            mismatches++;
        end
        if (got.status !== want.status)
        begin
            $error("status: expected %0h, got %0h", want.status, got.status);
            mismatches++;
        end
        if (want.last)
        begin
            case (want.status)
                ST_OK:      frames_ok++;
                ST_CRC:     frames_bad_crc++;
                ST_UNKNOWN: aborts_unknown++;
                ST_GAP:     aborts_gap++;
                default:    aborts_long++;
            endcase
        end
    endfunction

    // input side
    always @(posedge clk)
    begin : feeder
        logic more;
        if (rst_n)
        begin
            more = push;
            if (push && !full)
            begin
                deframe_word(item);
                items_accepted++;
                more = 1'b0;
            end
            if (!more)
            begin
                if (feed_hold != 0)
                    feed_hold <= feed_hold - 1;
                else if (pending.size() != 0)
                begin
                    item      <= pending.pop_front();
                    more      = 1'b1;
                    feed_hold <= steady_feed ? 0 : $urandom_range(0, 8);
                end
            end
            push <= more;
        end
    end

    // result side
    always @(posedge clk)
    begin : drainer
        int wait_next;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                check_word(result);
                wait_next = steady_drain ? 0 : $urandom_range(0, 8);
            end
            else
                wait_next = (drain_hold != 0) ? drain_hold - 1 : 0;
            drain_hold <= wait_next;
            pop        <= (wait_next == 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles == STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_byte(logic [7:0] b);
        item_t w;
        w.operation = OP_BYTE;
        w.rx_byte   = b;
        pending.push_back(w);
        queued_items++;
    endfunction

    // rx_byte is don't-care on a gap, so it is randomized
    function automatic void queue_gap();
        item_t w;
        w.operation = OP_GAP;
        w.rx_byte   = 8'($urandom_range(0, 255));
        pending.push_back(w);
        queued_items++;
    endfunction

    // cut: 0 complete frame, -1 random truncation point, else gap after that many bytes
    function automatic void queue_frame(logic [7:0] fc, int count, bit bad_crc, int cut);
        logic [7:0]  bytes_q[$];
        logic [15:0] crc;
        int          len;
        len = frame_length(fc);
        bytes_q.push_back(mir_slave);
        bytes_q.push_back(fc);
        if (len == NEEDS_COUNT)
        begin
            len = count + int'(LEN_COUNT);
            bytes_q.push_back(8'(count));
        end
        while (bytes_q.size() < len - 2)
            bytes_q.push_back(8'($urandom_range(0, 255)));
        crc = CRC_INIT;
        foreach (bytes_q[i])
            crc = crc16_step(crc, bytes_q[i]);
        if (bad_crc)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        bytes_q.push_back(crc[7:0]);
        bytes_q.push_back(crc[15:8]);
        if (cut < 0)
            cut = $urandom_range(1, len - 1);
        foreach (bytes_q[i])
        begin
            if (cut > 0 && i == cut)
            begin
                queue_gap();
                break;
            end
            queue_byte(bytes_q[i]);
        end
    endfunction

    function automatic logic [7:0] pick_known_code();
        case ($urandom_range(0, 4))
            0: return EXC_CODE | 8'($urandom_range(0, 15));
            1: return FC_COIL;
            // long code 6 replies are kept rare
            2: return (mir_task_pend && (mir_task_len < 32 || $urandom_range(0, 7) == 0))
                      ? FC_SINGLE : mir_write;
            3: return mir_read;
            default: return mir_write;
        endcase
    endfunction

    function automatic int pick_count();
        if ($urandom_range(0, 39) == 0)
            return $urandom_range(200, 251);
        return $urandom_range(0, 12);
    endfunction

    function automatic void queue_random(int stop_at);
        int         sel;
        logic [7:0] fc;
        while (queued_items < stop_at)
        begin
            sel = $urandom_range(0, 99);
            fc  = pick_known_code();
            if (sel < 60)
                queue_frame(fc, pick_count(), $urandom_range(0, 9) == 0, 0);
            else if (sel < 70)
                queue_frame(fc, pick_count(), 1'b0, -1);
            else if (sel < 78)
            begin
                queue_byte(mir_slave);
                queue_byte(8'($urandom_range(0, 255)));
            end
            else if (sel < 86)
            begin
                repeat ($urandom_range(1, 4))
                    queue_byte(8'($urandom_range(0, 255)));
            end
            else if (sel < 92)
                queue_gap();
            else if (sel < 96 && frame_length(mir_read) == NEEDS_COUNT)
            begin
                queue_byte(mir_slave);
                queue_byte(mir_read);
                queue_byte(8'($urandom_range(252, 255)));
            end
            else
            begin
                queue_byte(mir_slave);
                queue_gap();
            end
        end
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SLAVE_ADDR:  mir_slave     = val;
            REG_READ_FUNC:   mir_read      = val;
            REG_WRITE_FUNC:  mir_write     = val;
            REG_TASK_PEND:   mir_task_pend = val[0];
            REG_TASK_PARLEN: mir_task_len  = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [7:0] addr, input logic [7:0] rd,
                                 input logic [7:0] wr, input logic pend,
                                 input logic [7:0] plen);
        write_reg(REG_SLAVE_ADDR, addr);
        write_reg(REG_READ_FUNC, rd);
        write_reg(REG_WRITE_FUNC, wr);
        write_reg(REG_TASK_PEND, {7'd0, pend});
        write_reg(REG_TASK_PARLEN, plen);
        settings_used++;
    endtask

    // block is idle once everything queued is in and every word is out
    task automatic settle();
        while (pending.size() != 0 || push || frame_words_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed pass on reset settings
        queue_byte(8'h00);
        queue_gap();
        queue_frame(EXC_CODE | 8'h03, 0, 1'b0, 0);
        queue_frame(FC_COIL, 0, 1'b1, 0);
        queue_byte(mir_slave);
        queue_byte(8'h07);
        queue_byte(mir_slave);
        queue_byte(FC_COIL);
        queue_gap();
        queue_byte(mir_slave);
        queue_byte(mir_read);
        queue_byte(8'hFF);
        queue_frame(mir_read, 0, 1'b0, 0);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: load_settings(8'h00, 8'h04, 8'h0F, 1'b1, 8'd0);
                1: load_settings(8'hFF, 8'hFF, 8'h00, 1'b1, 8'd250);
                // read code shadowed by the fixed coil rule; write code 6 applies with no task pending
                2: load_settings(8'h11, FC_COIL, FC_SINGLE, 1'b0, 8'd3);
                default: load_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                       8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                                       8'($urandom_range(0, 250)));
            endcase
            steady_feed  = (ph % 2 == 1);
            steady_drain = (ph % 3 == 2);
            if (ph == 0)
                queue_frame(mir_read, 251, 1'b0, 0);  // longest frame accepted
            queue_random(queued_items + 215);
            settle();
        end

        repeat (16) @(posedge clk);
        $display("covered %0d input words and %0d result words over %0d register settings",
                 items_accepted, words_seen, settings_used);
        $display("frames %0d clean, %0d crc bad; aborts %0d unknown, %0d gap, %0d oversize",
                 frames_ok, frames_bad_crc, aborts_unknown, aborts_gap, aborts_long);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mbrtu_pkg.sv
hdl/mbrtu_front.sv
hdl/mbrtu_queue.sv
hdl/modbus_rtu_response_deframer_top.sv
tb/sv/tb_top.sv
